@@ sv/dtq_pkg.sv @@
package dtq_pkg;

    // Sizes of the slot table and the time base
    localparam int NUM_SLOTS = 16;
    localparam int TIME_W    = 32;
    localparam int MAX_OUT   = 16;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 32;
    localparam int STAT_W  = 3;

    // Derived widths
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int FIRE_W = $clog2(MAX_OUT);
    localparam int SUM_W  = ((TIME_W > DELAY_W) ? TIME_W : DELAY_W) + 1;
    localparam int MEM_W  = DELAY_W + TIME_W;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_ONCE   = 3'd0,
        MODE_REPEAT = 3'd1,
        MODE_CANCEL = 3'd2,
        MODE_TICK   = 3'd3,
        MODE_SHUT   = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_SHUT     = 3'd1,
        STAT_BUSY     = 3'd2,
        STAT_BADDELAY = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_FIRED    = 3'd5,
        STAT_IDLE     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DUE,
        S_DUE_END,
        S_SEL,
        S_FIRE,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic tick_start;
        logic scan_start;
        logic scan;
        logic due_phase;
        logic load_idle;
        logic fire;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic tick_run;
        logic scan_done;
        logic none_due;
        logic out_free;
        logic res_last;
    } t_sts;

endpackage

@@ sv/dtq_ctrl.sv @@
module dtq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dtq_pkg::t_sts i_sts,
    output logic          o_ready,
    output dtq_pkg::t_cmd o_cmd
);

    dtq_pkg::t_state r_state;
    dtq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (i_valid) n_state = dtq_pkg::S_DECODE;
            end
            dtq_pkg::S_DECODE: begin
                n_state = i_sts.tick_run ? dtq_pkg::S_DUE : dtq_pkg::S_EMIT;
            end
            dtq_pkg::S_DUE: begin
                if (i_sts.scan_done) n_state = dtq_pkg::S_DUE_END;
            end
            dtq_pkg::S_DUE_END: begin
                n_state = i_sts.none_due ? dtq_pkg::S_EMIT : dtq_pkg::S_SEL;
            end
            dtq_pkg::S_SEL: begin
                if (i_sts.scan_done) n_state = dtq_pkg::S_FIRE;
            end
            dtq_pkg::S_FIRE: begin
                n_state = dtq_pkg::S_EMIT;
            end
            dtq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.res_last ? dtq_pkg::S_IDLE : dtq_pkg::S_SEL;
                end
            end
            default: begin
                n_state = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            dtq_pkg::S_DECODE: begin
                if (i_sts.tick_run) begin
                    o_cmd.tick_start = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end else begin
                    o_cmd.exec = 1'b1;
                end
            end
            dtq_pkg::S_DUE: begin
                o_cmd.scan      = 1'b1;
                o_cmd.due_phase = 1'b1;
            end
            dtq_pkg::S_DUE_END: begin
                if (i_sts.none_due) begin
                    o_cmd.load_idle = 1'b1;
                end else begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            dtq_pkg::S_SEL: begin
                o_cmd.scan = 1'b1;
            end
            dtq_pkg::S_FIRE: begin
                o_cmd.fire = 1'b1;
            end
            dtq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.scan_start = !i_sts.res_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/dtq_dp.sv @@
module dtq_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtq_pkg::t_cmd                i_cmd,
    output dtq_pkg::t_sts                o_sts,
    input  logic [dtq_pkg::MODE_W-1:0]   i_mode,
    input  logic [dtq_pkg::ID_W-1:0]     i_task_id,
    input  logic [dtq_pkg::DELAY_W-1:0]  i_delay,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [dtq_pkg::STAT_W-1:0]   o_status,
    output logic [dtq_pkg::ID_W-1:0]     o_fired_task,
    output logic                         o_last
);

    // Latched input item
    logic [dtq_pkg::MODE_W-1:0]  r_mode;
    logic [dtq_pkg::ID_W-1:0]    r_id;
    logic [dtq_pkg::DELAY_W-1:0] r_delay;

    // Timer state
    logic [dtq_pkg::TIME_W-1:0]  r_time;
    logic                        r_shut;
    logic [dtq_pkg::NUM_SLOTS-1:0] r_active;
    logic [dtq_pkg::NUM_SLOTS-1:0] r_due;

    // Slot table: {period, deadline}
    logic [dtq_pkg::MEM_W-1:0]   r_mem [dtq_pkg::NUM_SLOTS];
    logic [dtq_pkg::MEM_W-1:0]   r_rd_data;

    // Scan and selection
    logic [dtq_pkg::IDX_W-1:0]   r_idx;
    logic                        r_rd_vld;
    logic [dtq_pkg::SLOT_W-1:0]  r_rd_idx;
    logic [dtq_pkg::CNT_W-1:0]   r_due_cnt;
    logic [dtq_pkg::FIRE_W-1:0]  r_fire_cnt;
    logic                        r_best_vld;
    logic [dtq_pkg::SLOT_W-1:0]  r_best;
    logic [dtq_pkg::TIME_W-1:0]  r_best_dl;
    logic [dtq_pkg::DELAY_W-1:0] r_best_per;

    // Staged result and output register
    logic [dtq_pkg::STAT_W-1:0]  r_res_status;
    logic [dtq_pkg::ID_W-1:0]    r_res_task;
    logic                        r_res_last;
    logic                        r_o_valid;
    logic [dtq_pkg::STAT_W-1:0]  r_o_status;
    logic [dtq_pkg::ID_W-1:0]    r_o_task;
    logic                        r_o_last;

    logic [dtq_pkg::SLOT_W-1:0]  slot;
    logic                        id_ok;
    logic [dtq_pkg::SUM_W-1:0]   sched_sum;
    logic                        sched_ovf;
    logic [dtq_pkg::SUM_W-1:0]   rearm_sum;
    logic [dtq_pkg::TIME_W-1:0]  rearm_dl;
    logic [dtq_pkg::TIME_W-1:0]  rd_dl;
    logic [dtq_pkg::DELAY_W-1:0] rd_per;
    logic                        rd_due;
    logic [dtq_pkg::STAT_W-1:0]  exec_status;
    logic                        exec_arm;
    logic                        exec_cancel;
    logic                        exec_shut;
    logic                        mem_we;
    logic [dtq_pkg::SLOT_W-1:0]  mem_addr;
    logic [dtq_pkg::MEM_W-1:0]   mem_wdata;
    logic                        fire_last;

    // Deadline arithmetic
    assign slot      = dtq_pkg::SLOT_W'(r_id);
    assign id_ok     = (32'(r_id) < dtq_pkg::NUM_SLOTS);
    assign sched_sum = dtq_pkg::SUM_W'(r_time) + dtq_pkg::SUM_W'(r_delay);
    assign sched_ovf = |sched_sum[dtq_pkg::SUM_W-1:dtq_pkg::TIME_W];
    assign rearm_sum = dtq_pkg::SUM_W'(r_time) + dtq_pkg::SUM_W'(r_best_per);
    assign rearm_dl  = (|rearm_sum[dtq_pkg::SUM_W-1:dtq_pkg::TIME_W])
                     ? dtq_pkg::TIME_MAX : rearm_sum[dtq_pkg::TIME_W-1:0];

    assign rd_dl  = r_rd_data[dtq_pkg::TIME_W-1:0];
    assign rd_per = r_rd_data[dtq_pkg::MEM_W-1:dtq_pkg::TIME_W];
    assign rd_due = r_active[r_rd_idx] && (rd_dl <= r_time);

    assign fire_last = (r_due_cnt == dtq_pkg::CNT_W'(1))
                    || (r_fire_cnt == dtq_pkg::FIRE_W'(dtq_pkg::MAX_OUT - 1));

    // Decode a non-tick item
    always_comb begin
        exec_status = dtq_pkg::STAT_DONE;
        exec_arm    = 1'b0;
        exec_cancel = 1'b0;
        exec_shut   = 1'b0;
        case (r_mode)
            dtq_pkg::MODE_ONCE, dtq_pkg::MODE_REPEAT: begin
                if (r_shut) begin
                    exec_status = dtq_pkg::STAT_SHUT;
                end else if (!id_ok) begin
                    exec_status = dtq_pkg::STAT_NOTFOUND;
                end else if (sched_ovf) begin
                    exec_status = dtq_pkg::STAT_BADDELAY;
                end else if (r_active[slot]) begin
                    exec_status = dtq_pkg::STAT_BUSY;
                end else begin
                    exec_arm = 1'b1;
                end
            end
            dtq_pkg::MODE_CANCEL: begin
                if (r_shut || !id_ok) begin
                    exec_status = dtq_pkg::STAT_NOTFOUND;
                end else if (!r_active[slot]) begin
                    exec_status = dtq_pkg::STAT_NOTFOUND;
                end else begin
                    exec_cancel = 1'b1;
                end
            end
            dtq_pkg::MODE_TICK: begin
                exec_status = dtq_pkg::STAT_SHUT;
            end
            dtq_pkg::MODE_SHUT: begin
                exec_shut = 1'b1;
            end
            default: begin
                exec_status = dtq_pkg::STAT_DONE;
            end
        endcase
    end

    // Slot table write port
    assign mem_we    = (i_cmd.exec && exec_arm) || (i_cmd.fire && (r_best_per != '0));
    assign mem_addr  = i_cmd.fire ? r_best : slot;
    assign mem_wdata = i_cmd.fire ? {r_best_per, rearm_dl}
                     : {((r_mode == dtq_pkg::MODE_REPEAT) ? r_delay : '0),
                        sched_sum[dtq_pkg::TIME_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_idx[dtq_pkg::SLOT_W-1:0]];
    end

    // Control state: time, shut-down flag, active marks, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_shut    <= 1'b0;
            r_active  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (exec_arm) r_active[slot] <= 1'b1;
                if (exec_cancel) r_active[slot] <= 1'b0;
                if (exec_shut) begin
                    r_shut   <= 1'b1;
                    r_active <= '0;
                end
            end
            if (i_cmd.tick_start && (r_time != dtq_pkg::TIME_MAX)) begin
                r_time <= r_time + 1'b1;
            end
            if (i_cmd.fire && (r_best_per == '0)) begin
                r_active[r_best] <= 1'b0;
            end
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Scan, selection, and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= i_mode;
            r_id    <= i_task_id;
            r_delay <= i_delay;
        end
        if (i_cmd.scan_start) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            // advance the read address, one slot per cycle
            if (r_idx < dtq_pkg::IDX_W'(dtq_pkg::NUM_SLOTS)) begin
                r_rd_vld <= 1'b1;
                r_rd_idx <= r_idx[dtq_pkg::SLOT_W-1:0];
                r_idx    <= r_idx + 1'b1;
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (r_rd_vld) begin
                if (i_cmd.due_phase) begin
                    r_due[r_rd_idx] <= rd_due;
                    r_due_cnt       <= r_due_cnt + dtq_pkg::CNT_W'(rd_due);
                end else if (r_due[r_rd_idx] && (!r_best_vld || (rd_dl < r_best_dl))) begin
                    // strict compare keeps the lower slot on ties
                    r_best_vld <= 1'b1;
                    r_best     <= r_rd_idx;
                    r_best_dl  <= rd_dl;
                    r_best_per <= rd_per;
                end
            end
        end
        if (i_cmd.tick_start) begin
            r_due      <= '0;
            r_due_cnt  <= '0;
            r_fire_cnt <= '0;
        end
        if (i_cmd.fire) begin
            r_due[r_best] <= 1'b0;
            r_due_cnt     <= r_due_cnt - 1'b1;
            r_fire_cnt    <= r_fire_cnt + 1'b1;
            r_res_status  <= dtq_pkg::STAT_FIRED;
            r_res_task    <= dtq_pkg::ID_W'(r_best);
            r_res_last    <= fire_last;
        end
        if (i_cmd.exec) begin
            r_res_status <= exec_status;
            r_res_task   <= '0;
            r_res_last   <= 1'b1;
        end
        if (i_cmd.load_idle) begin
            r_res_status <= dtq_pkg::STAT_IDLE;
            r_res_task   <= '0;
            r_res_last   <= 1'b1;
        end
        if (i_cmd.push) begin
            r_o_status <= r_res_status;
            r_o_task   <= r_res_task;
            r_o_last   <= r_res_last;
        end
    end

    // Status to the controller
    assign o_sts.tick_run  = (r_mode == dtq_pkg::MODE_TICK) && !r_shut;
    assign o_sts.scan_done = r_rd_vld
                          && (r_rd_idx == dtq_pkg::SLOT_W'(dtq_pkg::NUM_SLOTS - 1));
    assign o_sts.none_due  = (r_due_cnt == '0);
    assign o_sts.out_free  = !r_o_valid || i_ready;
    assign o_sts.res_last  = r_res_last;

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_fired_task = r_o_task;
    assign o_last       = r_o_last;

endmodule

@@ sv/deadline_timer_queue.sv @@
// Deadline timer queue: a table of task slots with deadlines and a time
// counter advanced by tick items. Input channel (i_valid/o_ready) carries
// i_mode, i_task_id and i_delay: schedule once, schedule repeated, cancel,
// tick or shut down. Output channel (o_valid/i_ready) carries o_status,
// o_fired_task and o_last; o_last marks the final result item of an input
// item. Schedule, cancel and shut down give one result: after acceptance the
// item is decoded and its result staged, then pushed into the output register
// once that register is free; o_ready returns after the push.
// A tick advances time and marks the due slots in a scan of the slot table
// (one slot table read per cycle, registered read data), then checks them;
// for each fired slot it scans for the earliest due deadline, fires that slot
// and emits its result. A tick with none due gives one idle result.
// Items are taken one at a time; o_ready is high only while the block is idle.
// Reset (i_rst_n low, synchronous) clears time, the active marks, the shut
// down flag and the output valid flag. A stalled receiver holds the result in
// the output register; the block waits to emit the next result item, and a
// new input item may be accepted while the last result still waits.
module deadline_timer_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dtq_pkg::MODE_W-1:0]   i_mode,
    input  logic [dtq_pkg::ID_W-1:0]     i_task_id,
    input  logic [dtq_pkg::DELAY_W-1:0]  i_delay,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dtq_pkg::STAT_W-1:0]   o_status,
    output logic [dtq_pkg::ID_W-1:0]     o_fired_task,
    output logic                         o_last
);

    dtq_pkg::t_cmd cmd;
    dtq_pkg::t_sts sts;

    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    dtq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_task_id    (i_task_id),
        .i_delay      (i_delay),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_fired_task (o_fired_task),
        .o_last       (o_last)
    );

    // Push a result only into a free output register
    a_push_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed into an occupied output register");

    // Take, exec, tick start, idle load, fire and push never overlap
    a_cmd_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.exec, cmd.tick_start, cmd.load_idle, cmd.fire, cmd.push}))
        else $error("overlapping datapath commands");

    // Input acceptance is followed by a decode cycle, never by a push
    a_take_decode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_ready && !cmd.push))
        else $error("accepted item not followed by decode");

endmodule

@@ bench/tb_deadline_timer_queue.sv @@
module tb_deadline_timer_queue;

    // Spare mode codes that the block must answer with done
    localparam logic [dtq_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [dtq_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [dtq_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        dtq_pkg::t_status         status;
        logic [dtq_pkg::ID_W-1:0] slot;
        logic                     last;
    } t_report;

    logic                         i_clk     = 1'b0;
    logic                         i_rst_n   = 1'b0;
    logic                         i_valid   = 1'b0;
    logic                         o_ready;
    logic [dtq_pkg::MODE_W-1:0]   i_mode    = '0;
    logic [dtq_pkg::ID_W-1:0]     i_task_id = '0;
    logic [dtq_pkg::DELAY_W-1:0]  i_delay   = '0;
    logic                         o_valid;
    logic                         i_ready   = 1'b0;
    logic [dtq_pkg::STAT_W-1:0]   o_status;
    logic [dtq_pkg::ID_W-1:0]     o_fired_task;
    logic                         o_last;

    // Shadow copy of the timer table
    logic [dtq_pkg::TIME_W-1:0]   tq_now = '0;
    logic [dtq_pkg::TIME_W-1:0]   tq_deadline [dtq_pkg::NUM_SLOTS];
    logic [dtq_pkg::DELAY_W-1:0]  tq_period   [dtq_pkg::NUM_SLOTS];
    logic                         tq_armed    [dtq_pkg::NUM_SLOTS];
    logic                         tq_halted = 1'b0;

    t_report             pending_reports [$];

    int                  tx_idle_pct  = 0;
    int                  rx_stall_pct = 0;
    logic                rx_hold_req  = 1'b0;
    int                  rx_hold_len  = 0;

    int                  mismatch_count = 0;
    int                  items_sent     = 0;
    int                  reports_seen   = 0;
    int                  fired_total    = 0;
    int                  widest_burst   = 0;

    deadline_timer_queue u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_task_id    (i_task_id),
        .i_delay      (i_delay),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_fired_task (o_fired_task),
        .o_last       (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++) begin
            tq_deadline[i] = '0;
            tq_period[i]   = '0;
            tq_armed[i]    = 1'b0;
        end
    end

    function automatic void post_report(dtq_pkg::t_status st,
                                        logic [dtq_pkg::ID_W-1:0] slot, logic fin);
        t_report r;
        r.status = st;
        r.slot   = slot;
        r.last   = fin;
        pending_reports.push_back(r);
    endfunction

    // Arm a slot at now + delay, or return the reason it is refused
    function automatic dtq_pkg::t_status tq_arm(logic [dtq_pkg::ID_W-1:0] id,
                                                logic [dtq_pkg::DELAY_W-1:0] delay,
                                                logic repeated);
        logic [dtq_pkg::TIME_W:0] due_at;
        due_at = {1'b0, tq_now} + {1'b0, delay};
        if (tq_halted)
            return dtq_pkg::STAT_SHUT;
        if (int'(id) >= dtq_pkg::NUM_SLOTS)
            return dtq_pkg::STAT_NOTFOUND;
        if (due_at[dtq_pkg::TIME_W])
            return dtq_pkg::STAT_BADDELAY;
        if (tq_armed[id])
            return dtq_pkg::STAT_BUSY;
        tq_armed[id]    = 1'b1;
        tq_deadline[id] = due_at[dtq_pkg::TIME_W-1:0];
        tq_period[id]   = repeated ? delay : '0;
        return dtq_pkg::STAT_DONE;
    endfunction

    // Advance time, then report due slots earliest first, lower slot on a tie (idle if none, shut if halted)
    function automatic void tq_tick();
        logic                     due   [dtq_pkg::NUM_SLOTS];
        logic [dtq_pkg::ID_W-1:0] order [dtq_pkg::MAX_OUT];
        int                       n;
        int                       best;
        logic [dtq_pkg::TIME_W:0] due_at;
        n = 0;
        if (tq_halted) begin
            post_report(dtq_pkg::STAT_SHUT, '0, 1'b1);
        end else begin
            if (tq_now != dtq_pkg::TIME_MAX)
                tq_now = tq_now + 1'b1;
            for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++)
                due[i] = tq_armed[i] && (tq_deadline[i] <= tq_now);
            while (n < dtq_pkg::MAX_OUT) begin
                best = -1;
                for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++) begin
                    if (due[i] && (best < 0 || tq_deadline[i] < tq_deadline[best]))
                        best = i;
                end
                if (best < 0)
                    break;
                due[best] = 1'b0;
                // drop one-shot slots, rearm repeated ones with saturation
                if (tq_period[best] == '0) begin
                    tq_armed[best] = 1'b0;
                end else begin
                    due_at = {1'b0, tq_now} + {1'b0, tq_period[best]};
                    tq_deadline[best] = due_at[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX
                                      : due_at[dtq_pkg::TIME_W-1:0];
                end
                order[n] = best[dtq_pkg::ID_W-1:0];
                n++;
            end
            if (n == 0)
                post_report(dtq_pkg::STAT_IDLE, '0, 1'b1);
            for (int k = 0; k < n; k++)
                post_report(dtq_pkg::STAT_FIRED, order[k], k == n - 1);
            fired_total += n;
            if (n > widest_burst)
                widest_burst = n;
        end
    endfunction

    function automatic void tq_step(logic [dtq_pkg::MODE_W-1:0] mode,
                                    logic [dtq_pkg::ID_W-1:0] id,
                                    logic [dtq_pkg::DELAY_W-1:0] delay);
        case (mode)
            dtq_pkg::MODE_ONCE: begin
                post_report(tq_arm(id, delay, 1'b0), '0, 1'b1);
            end
            dtq_pkg::MODE_REPEAT: begin
                post_report(tq_arm(id, delay, 1'b1), '0, 1'b1);
            end
            dtq_pkg::MODE_CANCEL: begin
                if (tq_halted || int'(id) >= dtq_pkg::NUM_SLOTS || !tq_armed[id]) begin
                    post_report(dtq_pkg::STAT_NOTFOUND, '0, 1'b1);
                end else begin
                    tq_armed[id] = 1'b0;
                    post_report(dtq_pkg::STAT_DONE, '0, 1'b1);
                end
            end
            dtq_pkg::MODE_TICK: begin
                tq_tick();
            end
            dtq_pkg::MODE_SHUT: begin
                tq_halted = 1'b1;
                for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++)
                    tq_armed[i] = 1'b0;
                post_report(dtq_pkg::STAT_DONE, '0, 1'b1);
            end
            default: begin
                post_report(dtq_pkg::STAT_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [dtq_pkg::MODE_W-1:0] mode,
                             input logic [dtq_pkg::ID_W-1:0] id,
                             input logic [dtq_pkg::DELAY_W-1:0] delay);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_task_id <= id;
        i_delay   <= delay;
        tq_step(mode, id, delay);
        forever begin
            @(posedge i_clk);
            if (o_ready)
                break;
        end
        items_sent++;
    endtask

    // Mostly schedules and ticks with small delays, some cancels and noise
    task automatic send_random_item();
        int                          pick;
        int                          span;
        int                          noise;
        logic [dtq_pkg::ID_W-1:0]    id;
        logic [dtq_pkg::DELAY_W-1:0] dly;
        int                          live [$];
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        id   = dtq_pkg::ID_W'($urandom_range(0, dtq_pkg::NUM_SLOTS - 1));
        if (span < 8)
            dly = $urandom_range(0, 8);
        else if (span == 8)
            dly = $urandom;
        else
            dly = dtq_pkg::TIME_MAX - $urandom_range(0, 15);
        if (pick < 38) begin
            send_item(pick[0] ? dtq_pkg::MODE_REPEAT : dtq_pkg::MODE_ONCE, id, dly);
        end else if (pick < 50) begin
            for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++)
                if (tq_armed[i])
                    live.push_back(i);
            if (live.size() != 0 && $urandom_range(0, 1) == 1)
                id = dtq_pkg::ID_W'(live[$urandom_range(0, live.size() - 1)]);
            send_item(dtq_pkg::MODE_CANCEL, id, dly);
        end else if (pick < 94) begin
            send_item(dtq_pkg::MODE_TICK, id, dly);
        end else begin
            noise = $urandom_range(0, 2);
            send_item(noise == 0 ? MODE_SPARE_A : (noise == 1 ? MODE_SPARE_B : MODE_SPARE_C),
                      id, dly);
        end
    endtask

    task automatic test_basic_ops();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(dtq_pkg::MODE_ONCE,   4'd3,  32'd0);
        send_item(dtq_pkg::MODE_REPEAT, 4'd7,  32'd2);
        send_item(dtq_pkg::MODE_ONCE,   4'd7,  32'd5);
        // deadline lands exactly on the top of the time range
        send_item(dtq_pkg::MODE_ONCE,   4'd0,  dtq_pkg::TIME_MAX);
        send_item(dtq_pkg::MODE_TICK,   4'd0,  32'd0);
        // deadline would overflow once time has moved
        send_item(dtq_pkg::MODE_ONCE,   4'd9,  dtq_pkg::TIME_MAX);
        send_item(dtq_pkg::MODE_CANCEL, 4'd0,  32'd0);
        send_item(dtq_pkg::MODE_CANCEL, 4'd0,  32'd0);
        // repeated with zero period behaves as one-shot
        send_item(dtq_pkg::MODE_REPEAT, 4'd12, 32'd0);
        send_item(dtq_pkg::MODE_ONCE,   4'd15, 32'd1);
        send_item(dtq_pkg::MODE_ONCE,   4'd4,  32'd1);
        send_item(dtq_pkg::MODE_TICK,   4'd0,  32'd0);
        send_item(dtq_pkg::MODE_TICK,   4'd0,  32'd0);
        send_item(dtq_pkg::MODE_TICK,   4'd0,  32'd0);
        send_item(dtq_pkg::MODE_CANCEL, 4'd7,  32'd0);
        send_item(MODE_SPARE_A, 4'd1, 32'd0);
        send_item(MODE_SPARE_B, 4'd2, 32'd0);
        send_item(MODE_SPARE_C, 4'd3, 32'd0);
    endtask

    // Arm every slot for the same tick so all sixteen fire in slot order
    task automatic test_full_table();
        for (int i = dtq_pkg::NUM_SLOTS - 1; i >= 0; i--)
            send_item((i % 3 == 0) ? dtq_pkg::MODE_REPEAT : dtq_pkg::MODE_ONCE,
                      i[dtq_pkg::ID_W-1:0], 32'd1);
        send_item(dtq_pkg::MODE_TICK, 4'd0, 32'd0);
        send_item(dtq_pkg::MODE_TICK, 4'd0, 32'd0);
        for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++)
            send_item(dtq_pkg::MODE_CANCEL, i[dtq_pkg::ID_W-1:0], 32'd0);
    endtask

    task automatic test_random_mix(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_random_item();
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_receiver_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_len  = HOLD_CYCLES;
        rx_hold_req  = 1'b1;
        send_item(dtq_pkg::MODE_REPEAT, 4'd6, 32'd1);
        send_item(dtq_pkg::MODE_ONCE,   4'd8, 32'd1);
        repeat (14) send_random_item();
    endtask

    task automatic test_shut_down();
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        send_item(dtq_pkg::MODE_REPEAT, 4'd2,  32'd3);
        send_item(dtq_pkg::MODE_ONCE,   4'd10, 32'd1);
        send_item(dtq_pkg::MODE_SHUT,   4'd0,  32'd0);
        send_item(dtq_pkg::MODE_ONCE,   4'd2,  32'd1);
        send_item(dtq_pkg::MODE_REPEAT, 4'd5,  32'd4);
        send_item(dtq_pkg::MODE_CANCEL, 4'd10, 32'd0);
        send_item(dtq_pkg::MODE_TICK,   4'd0,  32'd0);
        send_item(dtq_pkg::MODE_SHUT,   4'd0,  32'd0);
        send_item(MODE_SPARE_C, 4'd15, dtq_pkg::TIME_MAX);
    endtask

    // Check each accepted result, then drive ready for the next edge
    initial begin : rx_side
        int      hold_left;
        t_report want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: status %0d slot %0d last %0d",
                                 o_status, o_fired_task, o_last);
                end else begin
                    want = pending_reports.pop_front();
                    if (o_status !== want.status || o_fired_task !== want.slot ||
                        o_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: status %0d/%0d slot %0d/%0d last %0d/%0d %s",
                                     want.status, o_status, want.slot, o_fired_task,
                                     want.last, o_last, "(expected/actual)");
                    end
                end
            end
            if (rx_hold_req) begin
                hold_left   = rx_hold_len;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // End the run when no handshake happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_deadline_timer_queue: errors");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_full_table();
        test_random_mix(20, 0, 0);
        test_random_mix(20, 46, 0);
        test_random_mix(20, 0, 46);
        test_random_mix(20, 17, 17);
        test_receiver_hold();
        test_shut_down();
        i_valid <= 1'b0;
        // drain outstanding results, then let the block settle
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items and %0d results, %0d of them fired slots",
                 items_sent, reports_seen, fired_total);
        $display("widest tick burst %0d; idle and stall phases, long receiver hold, shut down",
                 widest_burst);
        if (mismatch_count == 0)
            $display("tb_deadline_timer_queue: clean");
        else
            $display("tb_deadline_timer_queue: errors");
        $finish;
    end

endmodule

@@ sim.f @@
sv/dtq_pkg.sv
sv/dtq_ctrl.sv
sv/dtq_dp.sv
sv/deadline_timer_queue.sv
bench/tb_deadline_timer_queue.sv
